@@ design/pss_pkg.sv @@
// Shared types, widths and helpers for the paired sample statistics block.
`default_nettype none
package pss_pkg;
	localparam int unsigned MAX_SAMPLES = 4096;
	localparam int CNT_W = 13;
	localparam int SMP_W = 24;
	localparam int SUM_W = 36;
	localparam int DSUM_W = 37;
	localparam int S2_W = 62;
	localparam int AD_W = 25;
	localparam int SQ_W = 50;
	localparam int MULA_W = 62;
	localparam int MULB_W = 36;
	localparam int PROD_W = 76;
	localparam int DIVN_W = 76;
	localparam int DIVD_W = 37;
	localparam int RAD_W = 64;
	localparam int ROOT_W = 32;
	localparam int NN_W = 26;
	localparam int MUL_CNT_W = $clog2(MULB_W);
	localparam int DIV_CNT_W = $clog2(DIVN_W);
	localparam int SQRT_CNT_W = $clog2(ROOT_W);

	typedef enum logic [4:0] {
		ST_ACCUM, ST_FLUSH, ST_DIV_B, ST_DIV_V, ST_DIV_D, ST_DIV_G, ST_DIV_R,
		ST_SQRT_R, ST_MUL_NS, ST_MUL_DD, ST_MUL_NN, ST_MUL_DEN, ST_DIV_SE,
		ST_SQRT_SE, ST_FINISH
	} pss_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_DIV_B, OP_DIV_V, OP_DIV_D, OP_DIV_G, OP_DIV_R, OP_SQRT_R,
		OP_MUL_NS, OP_MUL_DD, OP_MUL_NN, OP_MUL_DEN, OP_DIV_SE, OP_SQRT_SE
	} pss_op_t;

	typedef struct packed {
		logic    take;
		pss_op_t op;
		logic    start;
		logic    finish;
	} pss_cmd_t;

	typedef struct packed {
		logic last_acc;
		logic pipe_idle;
		logic done;
		logic multi;
		logic out_free;
	} pss_status_t;

	// Clamp an unsigned value to the 24-bit output range.
	function automatic logic [SMP_W-1:0] sat24(input logic [ROOT_W-1:0] v);
		return (|v[ROOT_W-1:SMP_W]) ? '1 : v[SMP_W-1:0];
	endfunction
endpackage
`default_nettype wire

@@ design/pss_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none
module pss_mul (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pss_pkg::MULA_W-1:0]   a,
	input  wire logic [pss_pkg::MULB_W-1:0]   b,
	output logic                              done,
	output logic      [pss_pkg::PROD_W-1:0]   prod
);
	logic                             busy_q, done_q;
	logic [pss_pkg::MUL_CNT_W-1:0]    cnt_q;
	logic [pss_pkg::MULA_W-1:0]       a_q;
	logic [pss_pkg::MULB_W-1:0]       b_q;
	logic [pss_pkg::PROD_W-1:0]       acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pss_pkg::MUL_CNT_W'(pss_pkg::MULB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[pss_pkg::PROD_W-2:0], 1'b0}
				+ (b_q[pss_pkg::MULB_W-1] ? pss_pkg::PROD_W'(a_q) : '0);
			b_q   <= {b_q[pss_pkg::MULB_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

@@ design/pss_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pss_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pss_pkg::DIVN_W-1:0]   num,
	input  wire logic [pss_pkg::DIVD_W-1:0]   den,
	output logic                              done,
	output logic      [pss_pkg::DIVN_W-1:0]   quo
);
	logic                             busy_q, done_q;
	logic [pss_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [pss_pkg::DIVN_W-1:0]       dvd_q;
	logic [pss_pkg::DIVD_W-1:0]       den_q, rem_q;
	logic [pss_pkg::DIVD_W:0]         rem_sh, rem_nxt;
	logic                             ge;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[pss_pkg::DIVN_W-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_nxt = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pss_pkg::DIV_CNT_W'(pss_pkg::DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register fills with quotient bits from the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt[pss_pkg::DIVD_W-1:0];
			dvd_q <= {dvd_q[pss_pkg::DIVN_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;
endmodule
`default_nettype wire

@@ design/pss_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none
module pss_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pss_pkg::RAD_W-1:0]    x,
	output logic                              done,
	output logic      [pss_pkg::ROOT_W-1:0]   root
);
	logic                             busy_q, done_q;
	logic [pss_pkg::SQRT_CNT_W-1:0]   cnt_q;
	logic [pss_pkg::RAD_W-1:0]        x_q;
	logic [pss_pkg::ROOT_W+1:0]       rem_q;
	logic [pss_pkg::ROOT_W-1:0]       root_q;
	logic [pss_pkg::ROOT_W+3:0]       rem_sh, trial, rem_nxt;
	logic                             ge;

	always_comb begin
		rem_sh  = {rem_q, x_q[pss_pkg::RAD_W-1:pss_pkg::RAD_W-2]};
		trial   = {2'b00, root_q, 2'b01};
		ge      = rem_sh >= trial;
		rem_nxt = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pss_pkg::SQRT_CNT_W'(pss_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[pss_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= rem_nxt[pss_pkg::ROOT_W+1:0];
			root_q <= {root_q[pss_pkg::ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

@@ design/pss_ctrl.sv @@
// Sequencer: accumulation phase, then the chain of divides, products and roots.
`default_nettype none
module pss_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pss_pkg::pss_status_t  st,
	output pss_pkg::pss_cmd_t          cmd
);
	pss_pkg::pss_state_t state_q, state_nxt;
	logic                launched_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pss_pkg::ST_ACCUM:   if (st.last_acc) state_nxt = pss_pkg::ST_FLUSH;
			pss_pkg::ST_FLUSH:   if (st.pipe_idle) state_nxt = pss_pkg::ST_DIV_B;
			pss_pkg::ST_DIV_B:   if (st.done) state_nxt = pss_pkg::ST_DIV_V;
			pss_pkg::ST_DIV_V:   if (st.done) state_nxt = pss_pkg::ST_DIV_D;
			pss_pkg::ST_DIV_D:   if (st.done) state_nxt = pss_pkg::ST_DIV_G;
			pss_pkg::ST_DIV_G:   if (st.done) state_nxt = pss_pkg::ST_DIV_R;
			pss_pkg::ST_DIV_R:   if (st.done) state_nxt = pss_pkg::ST_SQRT_R;
			pss_pkg::ST_SQRT_R: begin
				if (st.done)
					state_nxt = st.multi ? pss_pkg::ST_MUL_NS : pss_pkg::ST_FINISH;
			end
			pss_pkg::ST_MUL_NS:  if (st.done) state_nxt = pss_pkg::ST_MUL_DD;
			pss_pkg::ST_MUL_DD:  if (st.done) state_nxt = pss_pkg::ST_MUL_NN;
			pss_pkg::ST_MUL_NN:  if (st.done) state_nxt = pss_pkg::ST_MUL_DEN;
			pss_pkg::ST_MUL_DEN: if (st.done) state_nxt = pss_pkg::ST_DIV_SE;
			pss_pkg::ST_DIV_SE:  if (st.done) state_nxt = pss_pkg::ST_SQRT_SE;
			pss_pkg::ST_SQRT_SE: if (st.done) state_nxt = pss_pkg::ST_FINISH;
			pss_pkg::ST_FINISH:  if (st.out_free) state_nxt = pss_pkg::ST_ACCUM;
			default:             state_nxt = pss_pkg::ST_ACCUM;
		endcase
	end

	always_comb begin
		cmd.take   = 1'b0;
		cmd.op     = pss_pkg::OP_NONE;
		cmd.finish = 1'b0;
		unique case (state_q)
			pss_pkg::ST_ACCUM:   cmd.take = 1'b1;
			pss_pkg::ST_DIV_B:   cmd.op = pss_pkg::OP_DIV_B;
			pss_pkg::ST_DIV_V:   cmd.op = pss_pkg::OP_DIV_V;
			pss_pkg::ST_DIV_D:   cmd.op = pss_pkg::OP_DIV_D;
			pss_pkg::ST_DIV_G:   cmd.op = pss_pkg::OP_DIV_G;
			pss_pkg::ST_DIV_R:   cmd.op = pss_pkg::OP_DIV_R;
			pss_pkg::ST_SQRT_R:  cmd.op = pss_pkg::OP_SQRT_R;
			pss_pkg::ST_MUL_NS:  cmd.op = pss_pkg::OP_MUL_NS;
			pss_pkg::ST_MUL_DD:  cmd.op = pss_pkg::OP_MUL_DD;
			pss_pkg::ST_MUL_NN:  cmd.op = pss_pkg::OP_MUL_NN;
			pss_pkg::ST_MUL_DEN: cmd.op = pss_pkg::OP_MUL_DEN;
			pss_pkg::ST_DIV_SE:  cmd.op = pss_pkg::OP_DIV_SE;
			pss_pkg::ST_SQRT_SE: cmd.op = pss_pkg::OP_SQRT_SE;
			pss_pkg::ST_FINISH:  cmd.finish = st.out_free;
			default:             cmd.take = 1'b0;
		endcase
		// Each operation state fires its unit once, on its first cycle.
		cmd.start = (cmd.op != pss_pkg::OP_NONE) && !launched_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pss_pkg::ST_ACCUM;
			launched_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.start)
				launched_q <= 1'b1;
			else if (st.done)
				launched_q <= 1'b0;
		end
	end

	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		st.last_acc |=> state_q == pss_pkg::ST_FLUSH)
		else $error("last request did not enter flush");
	a_done_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		st.done |-> (state_q != pss_pkg::ST_ACCUM && state_q != pss_pkg::ST_FLUSH
			&& state_q != pss_pkg::ST_FINISH))
		else $error("unit completion outside an operation state");
	a_finish_back: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == pss_pkg::ST_ACCUM && !launched_q)
		else $error("finish did not return to accumulation");
endmodule
`default_nettype wire

@@ design/pss_datapath.sv @@
// Accumulators, arithmetic units, result registers and the output register.
`default_nettype none
module pss_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pss_pkg::pss_cmd_t             cmd,
	output pss_pkg::pss_status_t               st,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_wr_data,
	input  wire logic                          in_valid,
	input  wire logic signed [23:0]            baseline_sample,
	input  wire logic signed [23:0]            intervened_sample,
	input  wire logic                          last_pair,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic        [12:0]                 pair_count,
	output logic signed [23:0]                 baseline_avg,
	output logic signed [23:0]                 intervened_avg,
	output logic signed [24:0]                 delta_avg,
	output logic signed [24:0]                 degradation_avg,
	output logic        [23:0]                 standard_error,
	output logic        [23:0]                 rms_delta,
	output logic        [23:0]                 max_abs_delta,
	output logic        [16:0]                 degraded_fraction,
	output logic                               run_status
);
	logic                                 goal_q;
	logic                                 accept;
	logic [pss_pkg::CNT_W-1:0]            cnt_q, deg_q;
	logic                                 cap_q;
	logic signed [pss_pkg::SUM_W-1:0]     bsum_q, vsum_q;
	logic [pss_pkg::S2_W-1:0]             s2_q;
	logic [pss_pkg::AD_W-1:0]             maxad_q;

	logic signed [pss_pkg::AD_W-1:0]      d_in;
	logic [pss_pkg::AD_W-1:0]             ad_in;
	logic                                 vld_s1, vld_s2;
	logic signed [pss_pkg::SMP_W-1:0]     b_s1, v_s1, b_s2, v_s2;
	logic [pss_pkg::AD_W-1:0]             ad_s1, ad_s2;
	logic                                 deg_s1, deg_s2;
	logic [pss_pkg::SQ_W-1:0]             sq_s2;

	logic signed [pss_pkg::DSUM_W-1:0]    dsum;
	logic [pss_pkg::SUM_W-1:0]            babs, vabs, dabs;

	logic                                 mul_start, div_start, sqrt_start;
	logic                                 mul_done, div_done, sqrt_done;
	logic [pss_pkg::MULA_W-1:0]           mul_a;
	logic [pss_pkg::MULB_W-1:0]           mul_b;
	logic [pss_pkg::PROD_W-1:0]           prod;
	logic [pss_pkg::DIVN_W-1:0]           div_num, quo;
	logic [pss_pkg::DIVD_W-1:0]           div_den;
	logic                                 div_neg;
	logic [pss_pkg::ROOT_W-1:0]           root;
	logic signed [pss_pkg::SUM_W+1:0]     qs;

	logic [pss_pkg::PROD_W-1:0]           p1_q, num_q;
	logic [pss_pkg::NN_W-1:0]             nn_q;
	logic [pss_pkg::DIVD_W-1:0]           den_q;
	logic [pss_pkg::RAD_W-1:0]            rad_q;
	logic signed [23:0]                   bmean_q, vmean_q;
	logic signed [24:0]                   dmean_q;
	logic [16:0]                          frac_q;
	logic [23:0]                          rms_q, se_q;
	logic                                 out_valid_q;

	assign accept = in_valid && cmd.take;

	always_comb begin
		d_in  = pss_pkg::AD_W'(intervened_sample) - pss_pkg::AD_W'(baseline_sample);
		ad_in = d_in[pss_pkg::AD_W-1] ? -d_in : d_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			goal_q <= 1'b0;
		else if (cfg_wr_en)
			goal_q <= cfg_wr_data;
	end

	// Two-stage front end: difference and magnitude, then the square.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept && (cnt_q < pss_pkg::CNT_W'(pss_pkg::MAX_SAMPLES));
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		b_s1   <= baseline_sample;
		v_s1   <= intervened_sample;
		ad_s1  <= ad_in;
		deg_s1 <= goal_q ? (!d_in[pss_pkg::AD_W-1] && (|d_in)) : d_in[pss_pkg::AD_W-1];
		b_s2   <= b_s1;
		v_s2   <= v_s1;
		ad_s2  <= ad_s1;
		deg_s2 <= deg_s1;
		sq_s2  <= ad_s1 * ad_s1;
	end

	// Run state: the count moves at acceptance, the sums when the pair leaves the front end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			cap_q   <= 1'b0;
			bsum_q  <= '0;
			vsum_q  <= '0;
			s2_q    <= '0;
			maxad_q <= '0;
			deg_q   <= '0;
		end else if (cmd.finish) begin
			cnt_q   <= '0;
			cap_q   <= 1'b0;
			bsum_q  <= '0;
			vsum_q  <= '0;
			s2_q    <= '0;
			maxad_q <= '0;
			deg_q   <= '0;
		end else begin
			if (accept) begin
				if (cnt_q < pss_pkg::CNT_W'(pss_pkg::MAX_SAMPLES))
					cnt_q <= cnt_q + 1'b1;
				else
					cap_q <= 1'b1;
			end
			if (vld_s2) begin
				bsum_q <= bsum_q + pss_pkg::SUM_W'(b_s2);
				vsum_q <= vsum_q + pss_pkg::SUM_W'(v_s2);
				s2_q   <= s2_q + pss_pkg::S2_W'(sq_s2);
				deg_q  <= deg_q + pss_pkg::CNT_W'(deg_s2);
				if (ad_s2 > maxad_q)
					maxad_q <= ad_s2;
			end
		end
	end

	always_comb begin
		dsum = pss_pkg::DSUM_W'(vsum_q) - pss_pkg::DSUM_W'(bsum_q);
		babs = bsum_q[pss_pkg::SUM_W-1] ? pss_pkg::SUM_W'(-bsum_q) : pss_pkg::SUM_W'(bsum_q);
		vabs = vsum_q[pss_pkg::SUM_W-1] ? pss_pkg::SUM_W'(-vsum_q) : pss_pkg::SUM_W'(vsum_q);
		dabs = dsum[pss_pkg::DSUM_W-1] ? pss_pkg::SUM_W'(-dsum) : pss_pkg::SUM_W'(dsum);
	end

	// Operand selection for the shared units.
	always_comb begin
		div_num    = '0;
		div_den    = pss_pkg::DIVD_W'(cnt_q);
		div_neg    = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		unique case (cmd.op)
			pss_pkg::OP_DIV_B: begin
				div_num   = pss_pkg::DIVN_W'(babs);
				div_neg   = bsum_q[pss_pkg::SUM_W-1];
				div_start = cmd.start;
			end
			pss_pkg::OP_DIV_V: begin
				div_num   = pss_pkg::DIVN_W'(vabs);
				div_neg   = vsum_q[pss_pkg::SUM_W-1];
				div_start = cmd.start;
			end
			pss_pkg::OP_DIV_D: begin
				div_num   = pss_pkg::DIVN_W'(dabs);
				div_neg   = dsum[pss_pkg::DSUM_W-1];
				div_start = cmd.start;
			end
			pss_pkg::OP_DIV_G: begin
				div_num   = pss_pkg::DIVN_W'({deg_q, 16'h0000});
				div_start = cmd.start;
			end
			pss_pkg::OP_DIV_R: begin
				div_num   = pss_pkg::DIVN_W'(s2_q);
				div_start = cmd.start;
			end
			pss_pkg::OP_DIV_SE: begin
				div_num   = num_q;
				div_den   = den_q;
				div_start = cmd.start;
			end
			pss_pkg::OP_MUL_NS: begin
				mul_a     = s2_q;
				mul_b     = pss_pkg::MULB_W'(cnt_q);
				mul_start = cmd.start;
			end
			pss_pkg::OP_MUL_DD: begin
				mul_a     = pss_pkg::MULA_W'(dabs);
				mul_b     = dabs;
				mul_start = cmd.start;
			end
			pss_pkg::OP_MUL_NN: begin
				mul_a     = pss_pkg::MULA_W'(cnt_q);
				mul_b     = pss_pkg::MULB_W'(cnt_q);
				mul_start = cmd.start;
			end
			pss_pkg::OP_MUL_DEN: begin
				mul_a     = pss_pkg::MULA_W'(nn_q);
				mul_b     = pss_pkg::MULB_W'(cnt_q - 1'b1);
				mul_start = cmd.start;
			end
			pss_pkg::OP_SQRT_R, pss_pkg::OP_SQRT_SE: sqrt_start = cmd.start;
			default: mul_start = 1'b0;
		endcase
	end

	pss_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	pss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	pss_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (rad_q),
		.done   (sqrt_done),
		.root   (root)
	);

	// Division truncates toward zero: divide magnitudes, then restore the sign.
	assign qs = div_neg ? -(pss_pkg::SUM_W+2)'(quo[pss_pkg::SUM_W+1:0])
		: (pss_pkg::SUM_W+2)'(quo[pss_pkg::SUM_W+1:0]);

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.op)
				pss_pkg::OP_DIV_B:  bmean_q <= qs[23:0];
				pss_pkg::OP_DIV_V:  vmean_q <= qs[23:0];
				pss_pkg::OP_DIV_D:  dmean_q <= qs[24:0];
				pss_pkg::OP_DIV_G:  frac_q  <= quo[16:0];
				default:            rad_q   <= quo[pss_pkg::RAD_W-1:0];
			endcase
		end
		if (mul_done) begin
			case (cmd.op)
				pss_pkg::OP_MUL_NS: p1_q  <= prod;
				pss_pkg::OP_MUL_DD: num_q <= (p1_q >= prod) ? p1_q - prod : '0;
				pss_pkg::OP_MUL_NN: nn_q  <= prod[pss_pkg::NN_W-1:0];
				default:            den_q <= prod[pss_pkg::DIVD_W-1:0];
			endcase
		end
		if (sqrt_done) begin
			if (cmd.op == pss_pkg::OP_SQRT_R)
				rms_q <= pss_pkg::sat24(root);
			else
				se_q <= pss_pkg::sat24(root);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pair_count        <= cnt_q;
			baseline_avg      <= bmean_q;
			intervened_avg    <= vmean_q;
			delta_avg         <= dmean_q;
			degradation_avg   <= goal_q ? dmean_q : -dmean_q;
			standard_error    <= (cnt_q > pss_pkg::CNT_W'(1)) ? se_q : '0;
			rms_delta         <= rms_q;
			max_abs_delta     <= pss_pkg::sat24(pss_pkg::ROOT_W'(maxad_q));
			degraded_fraction <= frac_q;
			run_status        <= cap_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign st.last_acc  = accept && last_pair;
	assign st.pipe_idle = !vld_s1 && !vld_s2;
	assign st.done      = mul_done || div_done || sqrt_done;
	assign st.multi     = cnt_q > pss_pkg::CNT_W'(1);
	assign st.out_free  = !out_valid_q || out_ready;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pss_pkg::CNT_W'(pss_pkg::MAX_SAMPLES))
		else $error("pair count beyond capacity");
	a_finish_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q && cnt_q == '0 && !cap_q)
		else $error("finish did not load result and clear run");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mul_done, div_done, sqrt_done}))
		else $error("two arithmetic units completed together");
endmodule
`default_nettype wire

@@ design/paired_sample_statistics_core.sv @@
// Top level of the paired sample statistics block.
// Usage: pairs of signed Q8.16 samples arrive as requests on the in_valid /
// in_ready channel, and are accepted while the block accumulates.
// A pair with last_pair set closes the run; no result is given for others.
// After the last request the block stops taking pairs while a controller
// walks a sequence of divides, shift-add products and square roots: a
// pipeline drain, five divides and one root, and for runs of more than one
// pair four products plus one more divide and root; then the result is
// loaded into the output register and out_valid rises.
// The divider, multiplier and root units work one bit per cycle, and each is
// shared by all operations of its kind.
// Reset clears the run state, the goal (to maximize) and out_valid.
// The result sits in an output register on out_valid / out_ready; a new run
// is accepted while it waits. If the receiver stalls, the block finishes
// its next run's computation and then holds until the old result is taken.
// metric_goal is written via cfg_wr_en / cfg_wr_data; the user must do so
// only while idle, since the block itself does not enforce it.
`default_nettype none
module paired_sample_statistics_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [23:0] baseline_sample,
	input  wire logic signed [23:0] intervened_sample,
	input  wire logic               last_pair,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic        [12:0]      pair_count,
	output logic signed [23:0]      baseline_avg,
	output logic signed [23:0]      intervened_avg,
	output logic signed [24:0]      delta_avg,
	output logic signed [24:0]      degradation_avg,
	output logic        [23:0]      standard_error,
	output logic        [23:0]      rms_delta,
	output logic        [23:0]      max_abs_delta,
	output logic        [16:0]      degraded_fraction,
	output logic                    run_status
);
	pss_pkg::pss_cmd_t    cmd;
	pss_pkg::pss_status_t st;

	pss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	pss_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_valid          (in_valid),
		.baseline_sample   (baseline_sample),
		.intervened_sample (intervened_sample),
		.last_pair         (last_pair),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.pair_count        (pair_count),
		.baseline_avg      (baseline_avg),
		.intervened_avg    (intervened_avg),
		.delta_avg         (delta_avg),
		.degradation_avg   (degradation_avg),
		.standard_error    (standard_error),
		.rms_delta         (rms_delta),
		.max_abs_delta     (max_abs_delta),
		.degraded_fraction (degraded_fraction),
		.run_status        (run_status)
	);

	assign in_ready = cmd.take;
endmodule
`default_nettype wire
